// ===== sv/sfsc_pkg.sv =====
package sfsc_pkg;

   // Request operation codes.
   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_INIT       = 3'd1,
      OP_END        = 3'd2,
      OP_SET_RATE   = 3'd3,
      OP_SET_STEPS  = 3'd4,
      OP_INIT_STEPS = 3'd5,
      OP_START      = 3'd6,
      OP_STOP       = 3'd7
   } op_type;

   localparam int unsigned STEPS_W = 32;
   localparam int unsigned RATE_W  = 16;
   localparam int unsigned REPS_W  = 11;
   localparam int unsigned TICK_W  = 16;

   localparam logic [RATE_W-1:0] DEFAULT_RATE = 16'd100;
   localparam logic [RATE_W-1:0] RATE_LIMIT   = 16'd20000;
   localparam logic [RATE_W-1:0] MED_RATE     = 16'd77;
   localparam logic [RATE_W-1:0] LOW_RATE     = 16'd10;
   localparam logic [REPS_W-1:0] SLOW_REPS    = 11'd2000;

   // Restoring divider for 999 / rate, with rate limited to 1..77.
   localparam int unsigned QUO_W      = 10;
   localparam int unsigned DIVR_W     = 7;
   localparam logic [QUO_W-1:0] KHZ_MINUS_ONE = 10'd999;
   localparam int unsigned DIV_STEPS  = QUO_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef struct packed {
      logic load_req;
      logic exec;
      logic div_step;
      logic div_commit;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic needs_div;
   } stat_type;

endpackage

// ===== sv/sfsc_ctrl.sv =====
module sfsc_ctrl import sfsc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      C_IDLE,
      C_EXEC,
      C_DIV,
      C_DIVEND,
      C_OUT
   } ctrl_state_type;

   ctrl_state_type         state_ff;
   logic                   rsp_valid_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic                   slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == C_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.load_req   = req_valid && (state_ff == C_IDLE);
      cmd.exec       = (state_ff == C_EXEC);
      cmd.div_step   = (state_ff == C_DIV);
      cmd.div_commit = (state_ff == C_DIVEND);
      cmd.load_rsp   = (state_ff == C_OUT) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            C_IDLE: begin
               if (req_valid) begin
                  state_ff <= C_EXEC;
               end
            end
            C_EXEC: begin
               div_cnt_ff <= '0;
               state_ff   <= stat.needs_div ? C_DIV : C_OUT;
            end
            C_DIV: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= C_DIVEND;
               end
            end
            C_DIVEND: begin
               state_ff <= C_OUT;
            end
            C_OUT: begin
               if (slot_free) begin
                  state_ff <= C_IDLE;
               end
            end
            default: begin
               state_ff <= C_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== sv/sfsc_dp.sv =====
module sfsc_dp import sfsc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic [2:0]                req_op,
   input  logic                      req_direction,
   input  logic signed [STEPS_W-1:0] req_steps,
   input  logic [RATE_W-1:0]         req_rate,
   output logic                      rsp_status,
   output logic                      rsp_coil_a_dir,
   output logic                      rsp_coil_b_dir,
   output logic                      rsp_drive_enable,
   output logic                      rsp_is_stepping,
   output logic signed [STEPS_W-1:0] rsp_remaining_steps,
   output logic                      rsp_direction_now,
   output logic [RATE_W-1:0]         rsp_rate_now
);

   typedef enum logic [1:0] {
      MS_OFF      = 2'd0,
      MS_INITED   = 2'd1,
      MS_STEPPING = 2'd2,
      MS_HALTED   = 2'd3
   } motor_state_type;

   localparam logic [STEPS_W-1:0] MOST_NEG = {1'b1, {(STEPS_W-1){1'b0}}};

   // Latched request.
   op_type                op_ff;
   logic                  dir_req_ff;
   logic [STEPS_W-1:0]    steps_req_ff;
   logic [RATE_W-1:0]     rate_req_ff;

   // Motor state.
   motor_state_type       mstate_ff, mstate_in;
   logic [1:0]            phase_ff, phase_in;
   logic [STEPS_W-1:0]    steps_left_ff, steps_left_in;
   logic                  dir_ff, dir_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic [REPS_W-1:0]     reps_ff, reps_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic                  coil_a_ff, coil_a_in;
   logic                  coil_b_ff, coil_b_in;
   logic                  drive_ff, drive_in;
   logic                  status_ff, status_in;

   // Divider.
   logic [DIVR_W-1:0]     rem_ff;
   logic [QUO_W-1:0]      quo_ff;
   logic [DIVR_W:0]       trial;
   logic [DIVR_W:0]       divisor;
   logic                  qbit;

   logic [TICK_W-1:0]     tick_inc;
   logic [STEPS_W-1:0]    steps_dec;
   logic [QUO_W:0]        quo_ext;

   assign stat.needs_div = (op_ff == OP_SET_RATE) && (rate_req_ff != '0)
                           && (rate_req_ff <= MED_RATE);

   assign tick_inc  = tick_ff + 1'b1;
   assign steps_dec = (steps_left_ff == MOST_NEG) ? steps_left_ff : steps_left_ff - 1'b1;

   assign divisor = {1'b0, rate_req_ff[DIVR_W-1:0]};
   assign trial   = {rem_ff, quo_ff[QUO_W-1]};
   assign qbit    = (trial >= divisor);
   assign quo_ext = {1'b0, quo_ff};

   always_comb begin
      mstate_in     = mstate_ff;
      phase_in      = phase_ff;
      steps_left_in = steps_left_ff;
      dir_in        = dir_ff;
      rate_in       = rate_ff;
      reps_in       = reps_ff;
      tick_in       = tick_ff;
      coil_a_in     = coil_a_ff;
      coil_b_in     = coil_b_ff;
      drive_in      = drive_ff;
      status_in     = status_ff;
      if (cmd.div_commit) begin
         // Rates of ten and below round the repeat count up by one.
         reps_in = (rate_req_ff <= LOW_RATE) ? quo_ext + 1'b1 : quo_ext;
      end else if (cmd.exec) begin
         status_in = 1'b0;
         case (op_ff)
            OP_TICK: begin
               if (tick_inc > {{(TICK_W-REPS_W){1'b0}}, reps_ff}) begin
                  tick_in = '0;
                  case (mstate_ff)
                     MS_OFF: begin
                        drive_in = 1'b0;
                     end
                     MS_STEPPING: begin
                        steps_left_in = steps_dec;
                        if (steps_dec == '0 || steps_dec[STEPS_W-1]) begin
                           mstate_in = MS_HALTED;
                        end
                        drive_in  = 1'b1;
                        coil_a_in = !phase_ff[1];
                        coil_b_in = !(phase_ff[1] ^ phase_ff[0]);
                        phase_in  = dir_ff ? phase_ff - 1'b1 : phase_ff + 1'b1;
                     end
                     default: begin
                        if (steps_left_ff[STEPS_W-1]) begin
                           steps_left_in = '0;
                        end
                     end
                  endcase
               end else begin
                  tick_in = tick_inc;
               end
            end
            OP_INIT: begin
               if (mstate_ff != MS_OFF) begin
                  status_in = 1'b1;
               end else begin
                  steps_left_in = '0;
                  rate_in       = DEFAULT_RATE;
                  reps_in       = '0;
                  coil_a_in     = 1'b1;
                  coil_b_in     = 1'b1;
                  mstate_in     = MS_INITED;
               end
            end
            OP_END: begin
               if (mstate_ff == MS_OFF) begin
                  status_in = 1'b1;
               end else begin
                  mstate_in     = MS_OFF;
                  drive_in      = 1'b0;
                  steps_left_in = '0;
                  reps_in       = '0;
                  phase_in      = '0;
                  rate_in       = DEFAULT_RATE;
               end
            end
            OP_SET_RATE: begin
               rate_in = rate_req_ff;
               if (rate_req_ff > RATE_LIMIT) begin
                  status_in = 1'b1;
               end else if (rate_req_ff == '0) begin
                  reps_in = SLOW_REPS;
               end else if (rate_req_ff > MED_RATE) begin
                  reps_in = '0;
               end
            end
            OP_SET_STEPS: begin
               if (mstate_ff == MS_OFF) begin
                  status_in = 1'b1;
               end else begin
                  dir_in        = dir_req_ff;
                  steps_left_in = steps_req_ff;
               end
            end
            OP_INIT_STEPS: begin
               if (mstate_ff == MS_OFF || steps_req_ff == '0) begin
                  status_in = 1'b1;
               end else begin
                  dir_in        = dir_req_ff;
                  steps_left_in = steps_req_ff;
                  // The new count is nonzero, so only a running motor fails.
                  if (mstate_ff == MS_STEPPING) begin
                     status_in = 1'b1;
                  end else begin
                     mstate_in = MS_STEPPING;
                     drive_in  = 1'b1;
                  end
               end
            end
            OP_START: begin
               if (steps_left_ff == '0 || mstate_ff == MS_STEPPING) begin
                  status_in = 1'b1;
               end else begin
                  mstate_in = MS_STEPPING;
                  drive_in  = 1'b1;
               end
            end
            OP_STOP: begin
               if (mstate_ff == MS_OFF || mstate_ff == MS_HALTED) begin
                  status_in = 1'b1;
               end else begin
                  mstate_in = MS_HALTED;
               end
            end
            default: begin
               status_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mstate_ff     <= MS_OFF;
         phase_ff      <= '0;
         steps_left_ff <= '0;
         dir_ff        <= 1'b0;
         rate_ff       <= DEFAULT_RATE;
         reps_ff       <= '0;
         tick_ff       <= '0;
         coil_a_ff     <= 1'b0;
         coil_b_ff     <= 1'b0;
         drive_ff      <= 1'b0;
         status_ff     <= 1'b0;
      end else begin
         mstate_ff     <= mstate_in;
         phase_ff      <= phase_in;
         steps_left_ff <= steps_left_in;
         dir_ff        <= dir_in;
         rate_ff       <= rate_in;
         reps_ff       <= reps_in;
         tick_ff       <= tick_in;
         coil_a_ff     <= coil_a_in;
         coil_b_ff     <= coil_b_in;
         drive_ff      <= drive_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff        <= op_type'(req_op);
         dir_req_ff   <= req_direction;
         steps_req_ff <= req_steps;
         rate_req_ff  <= req_rate;
      end
      // One quotient bit per step; the dividend shifts out as the quotient shifts in.
      if (cmd.exec) begin
         rem_ff <= '0;
         quo_ff <= KHZ_MINUS_ONE;
      end else if (cmd.div_step) begin
         rem_ff <= qbit ? DIVR_W'(trial - divisor) : trial[DIVR_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], qbit};
      end
      if (cmd.load_rsp) begin
         rsp_status          <= status_ff;
         rsp_coil_a_dir      <= coil_a_ff;
         rsp_coil_b_dir      <= coil_b_ff;
         rsp_drive_enable    <= drive_ff;
         rsp_is_stepping     <= (mstate_ff == MS_STEPPING);
         rsp_remaining_steps <= steps_left_ff;
         rsp_direction_now   <= dir_ff;
         rsp_rate_now        <= rate_ff;
      end
   end

endmodule

// ===== sv/stepper_full_step_controller.sv =====
// Sequence: a request is taken when the controller is idle, executes, runs the divider
// for set_rate with a rate of 1 to 77, then waits until the response slot is free.
// Requests do not overlap: a new one is taken only once the last response is loaded;
// set_rate of 1 to 77 also runs the ten-step restoring divider that forms 999 / rate.
// Reset: synchronous; the motor returns to off, drive disabled, rate 100, counters zero.
module stepper_full_step_controller import sfsc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_op,
   input  logic                      req_direction,
   input  logic signed [STEPS_W-1:0] req_steps,
   input  logic [RATE_W-1:0]         req_rate,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_status,
   output logic                      rsp_coil_a_dir,
   output logic                      rsp_coil_b_dir,
   output logic                      rsp_drive_enable,
   output logic                      rsp_is_stepping,
   output logic signed [STEPS_W-1:0] rsp_remaining_steps,
   output logic                      rsp_direction_now,
   output logic [RATE_W-1:0]         rsp_rate_now
);

   cmd_type  cmd;
   stat_type stat;

   sfsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfsc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_op              (req_op),
      .req_direction       (req_direction),
      .req_steps           (req_steps),
      .req_rate            (req_rate),
      .rsp_status          (rsp_status),
      .rsp_coil_a_dir      (rsp_coil_a_dir),
      .rsp_coil_b_dir      (rsp_coil_b_dir),
      .rsp_drive_enable    (rsp_drive_enable),
      .rsp_is_stepping     (rsp_is_stepping),
      .rsp_remaining_steps (rsp_remaining_steps),
      .rsp_direction_now   (rsp_direction_now),
      .rsp_rate_now        (rsp_rate_now)
   );

   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // A stepping motor always has its drive enabled.
   a_step_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_stepping |-> rsp_drive_enable)
      else $error("stepping reported with drive disabled");

   // The repeat count is written only after the last divider step.
   a_div_order: assert property (@(posedge clock) disable iff (reset)
      cmd.div_commit |-> $past(cmd.div_step))
      else $error("divider result taken before the last step");

endmodule
